// ===== src/tpss_pkg.sv =====
package tpss_pkg;

  // Field widths of the channels and the configuration port.
  localparam int RW_W       = 31;
  localparam int CS_W       = 18;
  localparam int CR_W       = 16;
  localparam int CI_W       = 10;
  localparam int PL_W       = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Default store depth and the widest length the divide-by-three supports.
  localparam int MAX_LENGTH_DEF = 1024;
  localparam int LEN3_W         = 17;
  localparam logic [LEN3_W-1:0] DIV3_MUL = 17'd43691;

  // Width of the iteration counter of the shared divider.
  localparam int DIV_CNT_W = $clog2(RW_W + 1);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_POLY_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_OFFSET = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [PL_W-1:0] POLY_LENGTH_RST  = 11'd1024;
  localparam logic [CR_W-1:0] MODULUS_RST      = 16'd2;
  localparam logic [CR_W-1:0] FIRST_OFFSET_RST = 16'd0;

  // Two-bit coefficient codes held in the store.
  localparam logic [1:0] CODE_ZERO  = 2'd0;
  localparam logic [1:0] CODE_PLUS  = 2'd1;
  localparam logic [1:0] CODE_MINUS = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_word;
    logic set_len;
    logic sweep_from_pos;
    logic sweep_from_len;
    logic sweep_clear;
    logic sweep_finish;
    logic div_start_j;
    logic div_start_m;
    logic div_step;
    logic cap_ci;
    logic rd_j;
    logic write_j;
    logic clear_i;
    logic load_out;
    logic pos_advance;
  } tpss_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pos_ge_len;
    logic sweep_done;
    logic div_last;
    logic need_mod;
    logic fin;
    logic dirty_above_len;
    logic out_free;
  } tpss_sts_t;

  // Floor of x / 3 by a reciprocal multiply; exact for x below 2**17.
  function automatic logic [LEN3_W-1:0] div3(input logic [LEN3_W-1:0] x);
    logic [2*LEN3_W-1:0] p;
    p = x * DIV3_MUL;
    return p[2*LEN3_W-1:LEN3_W];
  endfunction

endpackage

// ===== src/tpss_in_if.sv =====
interface tpss_in_if;
  logic                      valid;
  logic                      ready;
  logic [tpss_pkg::RW_W-1:0] random_word;

  modport source (output valid, output random_word, input ready);
  modport sink   (input valid, input random_word, output ready);
endinterface

// ===== src/tpss_out_if.sv =====
interface tpss_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [tpss_pkg::CS_W-1:0] coeff_signed;
  logic        [tpss_pkg::CR_W-1:0] coeff_reduced;
  logic        [tpss_pkg::CI_W-1:0] coeff_index;
  logic                             last;

  modport source (output valid, output coeff_signed, output coeff_reduced,
                  output coeff_index, output last, input ready);
  modport sink   (input valid, input coeff_signed, input coeff_reduced,
                  input coeff_index, input last, output ready);
endinterface

// ===== src/tpss_ctrl.sv =====
module tpss_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tpss_pkg::tpss_sts_t sts_i,
  output tpss_pkg::tpss_cmd_t cmd_o
);

  localparam logic [3:0] S_SWEEP = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_CHK   = 4'd2;
  localparam logic [3:0] S_PREP  = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_RDJ   = 4'd5;
  localparam logic [3:0] S_WRJ   = 4'd6;
  localparam logic [3:0] S_CLRI  = 4'd7;
  localparam logic [3:0] S_MOD   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0] state_q, state_d;
  logic       then_step_q, then_step_d;

  // Reset starts in the sweep so the whole store is cleared first.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SWEEP;
      then_step_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      then_step_q <= then_step_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    then_step_d = then_step_q;
    cmd_o       = '0;
    unique case (state_q)
      S_SWEEP: begin
        if (sts_i.sweep_done) begin
          cmd_o.sweep_finish = 1'b1;
          state_d = then_step_q ? S_PREP : S_IDLE;
        end else begin
          cmd_o.sweep_clear = 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take_word = 1'b1;
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        cmd_o.set_len = 1'b1;
        if (sts_i.pos_ge_len) begin
          cmd_o.sweep_from_pos = 1'b1;
          then_step_d = 1'b1;
          state_d = S_SWEEP;
        end else begin
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        cmd_o.div_start_j = 1'b1;
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          cmd_o.cap_ci = 1'b1;
          state_d = S_RDJ;
        end
      end
      S_RDJ: begin
        cmd_o.rd_j = 1'b1;
        state_d = S_WRJ;
      end
      S_WRJ: begin
        cmd_o.write_j = 1'b1;
        state_d = S_CLRI;
      end
      S_CLRI: begin
        cmd_o.clear_i = 1'b1;
        if (sts_i.need_mod) begin
          cmd_o.div_start_m = 1'b1;
          state_d = S_MOD;
        end else begin
          state_d = S_OUT;
        end
      end
      S_MOD: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out    = 1'b1;
          cmd_o.pos_advance = 1'b1;
          if (sts_i.fin && sts_i.dirty_above_len) begin
            cmd_o.sweep_from_len = 1'b1;
            then_step_d = 1'b0;
            state_d = S_SWEEP;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== src/tpss_dp.sv =====
module tpss_dp #(
  parameter int MAX_LENGTH = tpss_pkg::MAX_LENGTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [tpss_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [tpss_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic [tpss_pkg::RW_W-1:0]           word_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic signed [tpss_pkg::CS_W-1:0]    coeff_signed_o,
  output logic [tpss_pkg::CR_W-1:0]           coeff_reduced_o,
  output logic [tpss_pkg::CI_W-1:0]           coeff_index_o,
  output logic                                last_o,
  input  tpss_pkg::tpss_cmd_t                 cmd_i,
  output tpss_pkg::tpss_sts_t                 sts_o
);

  localparam int AW  = $clog2(MAX_LENGTH);
  localparam int LW  = $clog2(MAX_LENGTH + 1);
  localparam int DVW = (LW > tpss_pkg::CR_W) ? LW : tpss_pkg::CR_W;
  localparam int MODPAD_W = tpss_pkg::RW_W - tpss_pkg::CS_W + 1;

  // Configuration registers.
  logic [tpss_pkg::PL_W-1:0] poly_length_q;
  logic [tpss_pkg::CR_W-1:0] modulus_q;
  logic [tpss_pkg::CR_W-1:0] first_offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_length_q  <= tpss_pkg::POLY_LENGTH_RST;
      modulus_q      <= tpss_pkg::MODULUS_RST;
      first_offset_q <= tpss_pkg::FIRST_OFFSET_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tpss_pkg::REG_POLY_LENGTH:  poly_length_q  <= cfg_data_i[tpss_pkg::PL_W-1:0];
        tpss_pkg::REG_MODULUS:      modulus_q      <= cfg_data_i;
        tpss_pkg::REG_FIRST_OFFSET: first_offset_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective length: zero acts as one, anything above the store saturates.
  logic [LW-1:0] eff_len;
  always_comb begin
    if (poly_length_q == '0) begin
      eff_len = LW'(1);
    end else if (32'(poly_length_q) > 32'(MAX_LENGTH)) begin
      eff_len = LW'(MAX_LENGTH);
    end else begin
      eff_len = LW'(poly_length_q);
    end
  end

  // Step state.
  logic [AW-1:0]               pos_q;
  logic [LW-1:0]               len_q;
  logic [LW-1:0]               third_q;
  logic [LW-1:0]               ptr_q;
  logic [LW-1:0]               dirty_q;
  logic [1:0]                  ci_q;
  logic signed [tpss_pkg::CS_W-1:0] v_q;

  // Divider registers.
  logic [tpss_pkg::RW_W-1:0]      dvd_q;
  logic [DVW-1:0]                 rem_q;
  logic [DVW-1:0]                 dsr_q;
  logic [tpss_pkg::DIV_CNT_W-1:0] cnt_q;

  // Store of moved codes: bit 2 marks a moved entry.
  logic [2:0]    mem_q [MAX_LENGTH];
  logic [2:0]    rd_data_q;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [2:0]    mem_wd;
  logic [AW-1:0] mem_ra;

  // Output register.
  logic                             out_valid_q;
  logic signed [tpss_pkg::CS_W-1:0] out_signed_q;
  logic [tpss_pkg::CR_W-1:0]        out_reduced_q;
  logic [tpss_pkg::CI_W-1:0]        out_index_q;
  logic                             out_last_q;

  logic [AW-1:0]       j_pos;
  logic [LW-1:0]       span;
  logic [LW-1:0]       j_top;
  logic [1:0]          cj;
  logic signed [tpss_pkg::CS_W-1:0] v_d;
  logic [DVW:0]        trial;
  logic [DVW:0]        diff;
  logic [tpss_pkg::CR_W-1:0] reduced;
  logic                fin;
  logic                need_mod;

  // Code at a position: the stored code when moved, else the initial layout.
  function automatic logic [1:0] code_at(input logic [2:0] ent, input logic [AW-1:0] x,
                                         input logic [LW-1:0] third);
    logic [LW:0] xe;
    logic [LW:0] t1;
    logic [LW:0] t2;
    xe = (LW+1)'(x);
    t1 = {1'b0, third};
    t2 = {third, 1'b0};
    if (ent[2]) begin
      return ent[1:0];
    end else if (xe < t1) begin
      return tpss_pkg::CODE_PLUS;
    end else if (xe < t2) begin
      return tpss_pkg::CODE_MINUS;
    end else begin
      return tpss_pkg::CODE_ZERO;
    end
  endfunction

  assign j_pos = pos_q + rem_q[AW-1:0];
  assign span  = len_q - LW'(pos_q);
  assign j_top = LW'(j_pos) + LW'(1);
  assign fin   = (LW'(pos_q) == len_q - LW'(1));
  assign cj    = code_at(rd_data_q, j_pos, third_q);

  // Signed value of the coefficient; the offset goes onto coefficient zero.
  always_comb begin
    unique case (cj)
      tpss_pkg::CODE_PLUS:  v_d = tpss_pkg::CS_W'(1);
      tpss_pkg::CODE_MINUS: v_d = '1;
      default:              v_d = '0;
    endcase
    if (pos_q == '0) begin
      v_d = v_d + $signed({2'b00, first_offset_q});
    end
  end

  // Only a non-negative coefficient zero can reach the modulus.
  assign need_mod = (pos_q == '0) && !v_q[tpss_pkg::CS_W-1] && (modulus_q != '0);

  // Floor modulo for the small values; the divider covers the rest.
  always_comb begin
    if (modulus_q == '0) begin
      reduced = '0;
    end else if (need_mod) begin
      reduced = rem_q[tpss_pkg::CR_W-1:0];
    end else if (modulus_q == tpss_pkg::CR_W'(1)) begin
      reduced = '0;
    end else if (v_q[tpss_pkg::CS_W-1]) begin
      reduced = modulus_q - tpss_pkg::CR_W'(1);
    end else begin
      reduced = v_q[tpss_pkg::CR_W-1:0];
    end
  end

  // One restoring division step per cycle.
  assign trial = {rem_q, dvd_q[tpss_pkg::RW_W-1]};
  assign diff  = trial - {1'b0, dsr_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_word) begin
      dvd_q <= word_i;
    end
    if (cmd_i.div_start_j) begin
      dsr_q <= DVW'(span);
      rem_q <= '0;
      cnt_q <= tpss_pkg::DIV_CNT_W'(tpss_pkg::RW_W);
    end else if (cmd_i.div_start_m) begin
      dvd_q <= {v_q[tpss_pkg::CS_W-2:0], MODPAD_W'(0)};
      dsr_q <= DVW'(modulus_q);
      rem_q <= '0;
      cnt_q <= tpss_pkg::DIV_CNT_W'(tpss_pkg::CS_W - 1);
    end else if (cmd_i.div_step) begin
      rem_q <= diff[DVW] ? trial[DVW-1:0] : diff[DVW-1:0];
      dvd_q <= {dvd_q[tpss_pkg::RW_W-2:0], 1'b0};
      cnt_q <= cnt_q - tpss_pkg::DIV_CNT_W'(1);
    end
    if (cmd_i.set_len) begin
      len_q <= eff_len;
    end
    if (cmd_i.div_start_j) begin
      third_q <= LW'(tpss_pkg::div3(tpss_pkg::LEN3_W'(len_q)));
    end
    if (cmd_i.cap_ci) begin
      ci_q <= code_at(rd_data_q, pos_q, third_q);
    end
    if (cmd_i.write_j) begin
      v_q <= v_d;
    end
  end

  // Position, sweep pointer and the top of the possibly moved entries.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      ptr_q   <= '0;
      dirty_q <= LW'(MAX_LENGTH);
    end else begin
      if (cmd_i.sweep_from_pos) begin
        ptr_q <= LW'(pos_q);
      end else if (cmd_i.sweep_from_len) begin
        ptr_q <= len_q;
      end else if (cmd_i.sweep_clear) begin
        ptr_q <= ptr_q + LW'(1);
      end
      if (cmd_i.sweep_finish) begin
        dirty_q <= '0;
        pos_q   <= '0;
      end else if (cmd_i.write_j) begin
        if (j_top > dirty_q) begin
          dirty_q <= j_top;
        end
      end else if (cmd_i.pos_advance) begin
        if (fin) begin
          pos_q <= '0;
          if (!(dirty_q > len_q)) begin
            dirty_q <= '0;
          end
        end else begin
          pos_q <= pos_q + AW'(1);
        end
      end
    end
  end

  // Store port selection: sweep, moved code at j, or clearing of i.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = pos_q;
    mem_wd = '0;
    if (cmd_i.sweep_clear) begin
      mem_we = 1'b1;
      mem_wa = ptr_q[AW-1:0];
    end else if (cmd_i.write_j) begin
      mem_we = 1'b1;
      mem_wa = j_pos;
      mem_wd = {1'b1, ci_q};
    end else if (cmd_i.clear_i) begin
      mem_we = 1'b1;
    end
  end

  assign mem_ra = cmd_i.rd_j ? j_pos : pos_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rd_data_q <= mem_q[mem_ra];
  end

  // Output register: a waiting result does not hold up taking the next item, only its load.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_signed_q  <= v_q;
      out_reduced_q <= reduced;
      out_index_q   <= tpss_pkg::CI_W'(pos_q);
      out_last_q    <= fin;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign coeff_signed_o  = out_signed_q;
  assign coeff_reduced_o = out_reduced_q;
  assign coeff_index_o   = out_index_q;
  assign last_o          = out_last_q;

  // Status toward the controller.
  assign sts_o.pos_ge_len      = (LW'(pos_q) >= eff_len);
  assign sts_o.sweep_done      = (ptr_q >= dirty_q);
  assign sts_o.div_last        = (cnt_q == tpss_pkg::DIV_CNT_W'(1));
  assign sts_o.need_mod        = need_mod;
  assign sts_o.fin             = fin;
  assign sts_o.dirty_above_len = (dirty_q > len_q);
  assign sts_o.out_free        = !out_valid_q || out_ready_i;

endmodule

// ===== src/ternary_poly_shuffle_sampler_core.sv =====
// Ternary polynomial sampler: each random_word beat yields the next coefficient of a
// polynomial of poly_length coefficients (one third +1, one third -1, the rest 0)
// shuffled by forward Fisher-Yates; coefficient 0 carries first_offset, and last marks
// the final coefficient. For each coefficient the one-bit-per-cycle divider reduces
// the word modulo the remaining length, followed by a read and two writes on the move
// store, which has one read and one write port. For coefficient 0, when its value is
// not negative and the modulus is not zero, the same divider then reduces offset plus
// value modulo the modulus. A new word is taken while a finished coefficient still
// waits on the output. After reset the whole store is cleared, one entry per cycle,
// and the pass is closed before the first beat is taken; if the length is lowered
// mid-polynomial, the entries above it are swept the same way, one per cycle.
// Configuration writes are accepted at any time.
module ternary_poly_shuffle_sampler_core #(
  parameter int MAX_LENGTH = tpss_pkg::MAX_LENGTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tpss_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tpss_pkg::CFG_DATA_W-1:0] cfg_data_i,
  tpss_in_if.sink                         in_i,
  tpss_out_if.source                      out_o
);

  tpss_pkg::tpss_cmd_t cmd;
  tpss_pkg::tpss_sts_t sts;

  // Controller.
  tpss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath with divider, move store and output register.
  tpss_dp #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .word_i          (in_i.random_word),
    .out_ready_i     (out_o.ready),
    .out_valid_o     (out_o.valid),
    .coeff_signed_o  (out_o.coeff_signed),
    .coeff_reduced_o (out_o.coeff_reduced),
    .coeff_index_o   (out_o.coeff_index),
    .last_o          (out_o.last),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

endmodule

// ===== src/tpss_checker.sv =====
module tpss_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [tpss_pkg::CS_W-1:0]   out_signed_i,
  input logic [tpss_pkg::CI_W-1:0]   out_index_i,
  input logic                        out_last_i
);

  logic                      in_acc;
  logic                      out_acc;
  logic [1:0]                pend_q;
  logic                      prev_last_q;
  logic [tpss_pkg::CI_W-1:0] prev_idx_q;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // Beats accepted but not yet delivered, and the previous delivered index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      prev_last_q <= 1'b1;
      prev_idx_q  <= '0;
    end else begin
      if (in_acc && !out_acc) begin
        pend_q <= pend_q + 2'd1;
      end else if (out_acc && !in_acc) begin
        pend_q <= pend_q - 2'd1;
      end
      if (out_acc) begin
        prev_last_q <= out_last_i;
        prev_idx_q  <= out_index_i;
      end
    end
  end

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_signed_i) &&
      $stable(out_index_i))
    else $error("result changed while stalled");

  // At most one beat is taken ahead of the result that waits.
  a_pend_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("too many beats in flight");

  // No result without an accepted beat behind it.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != 2'd0)
    else $error("result without input beat");

  // A new polynomial starts at coefficient zero.
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && prev_last_q |-> out_index_i == '0)
    else $error("polynomial did not restart at zero");

  // Within a polynomial the index steps by one, or restarts on a length change.
  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !prev_last_q |->
      (out_index_i == '0) || (out_index_i == prev_idx_q + tpss_pkg::CI_W'(1)))
    else $error("coefficient index skipped");

endmodule

bind ternary_poly_shuffle_sampler_core tpss_checker u_tpss_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_signed_i (out_o.coeff_signed),
  .out_index_i  (out_o.coeff_index),
  .out_last_i   (out_o.last)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  // Store depth of the block as instantiated.
  localparam int STORE_DEPTH = tpss_pkg::MAX_LENGTH_DEF;
  // Register index that the block does not decode.
  localparam logic [tpss_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  // Random beats after the directed table.
  localparam int RANDOM_WORDS = 830;
  // Cycles the receiver holds off once to back up the block.
  localparam int BACKPRESSURE_CYCLES = 400;
  // Cycles waited after the last coefficient has come out, before judging.
  localparam int SETTLE_CYCLES = 64;
  localparam int DRAIN_LIMIT = 50000;
  localparam int PRINT_LIMIT = 40;

  // One coefficient beat on the output channel.
  typedef struct packed {
    logic signed [tpss_pkg::CS_W-1:0] cs;
    logic [tpss_pkg::CR_W-1:0]        cr;
    logic [tpss_pkg::CI_W-1:0]        idx;
    logic                             last;
  } coeff_t;

  typedef enum bit {ROW_WORD, ROW_CFG} row_kind_e;

  // One row of the directed table: a register write or a random word.
  typedef struct packed {
    row_kind_e                       kind;
    logic [tpss_pkg::CFG_IDX_W-1:0]  reg_idx;
    logic [tpss_pkg::CFG_DATA_W-1:0] data;
    logic [tpss_pkg::RW_W-1:0]       word;
    bit                              typed;
    coeff_t                          want;
  } plan_row_t;

  localparam coeff_t NO_COEFF = '0;
  localparam int PLAN_ROWS = 34;

  // Directed table; coefficients that follow plainly from the rules are typed in.
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    // After reset: length 1024, coefficient 0 is +1 and 1 mod 2 is 1.
    '{ROW_WORD, REG_UNUSED, 16'h0000, 31'h0000_0000, 1'b1, '{18'd1, 16'd1, 10'd0, 1'b0}},
    '{ROW_WORD, REG_UNUSED, 16'h0000, 31'h7FFF_FFFF, 1'b0, NO_COEFF},
    // Length zero acts as one and restarts the polynomial mid-way.
    '{ROW_CFG, tpss_pkg::REG_FIRST_OFFSET, 16'hFFFF, 31'h0, 1'b0, NO_COEFF},
    '{ROW_CFG, tpss_pkg::REG_MODULUS, 16'hFFFF, 31'h0, 1'b0, NO_COEFF},
    '{ROW_CFG, tpss_pkg::REG_POLY_LENGTH, 16'h0000, 31'h0, 1'b0, NO_COEFF},
    '{ROW_WORD, REG_UNUSED, 16'h0000, 31'h5555_5555, 1'b1,
      '{18'd65535, 16'd0, 10'd0, 1'b1}},
    // Modulus zero and modulus one both reduce to zero.
    '{ROW_CFG, tpss_pkg::REG_MODULUS, 16'h0000, 31'h0, 1'b0, NO_COEFF},
    '{ROW_WORD, REG_UNUSED, 16'h0000, 31'h2AAA_AAAA, 1'b1,
      '{18'd65535, 16'd0, 10'd0, 1'b1}},
    '{ROW_CFG, tpss_pkg::REG_MODULUS, 16'h0001, 31'h0, 1'b0, NO_COEFF},
    '{ROW_WORD, REG_UNUSED, 16'h0000, 31'h0000_0000, 1'b1,
      '{18'd65535, 16'd0, 10'd0, 1'b1}},
    // Length three: one +1, one -1, one zero.
    '{ROW_CFG, tpss_pkg::REG_MODULUS, 16'hFFFF, 31'h0, 1'b0, NO_COEFF},
    '{ROW_CFG, tpss_pkg::REG_FIRST_OFFSET, 16'h0000, 31'h0, 1'b0, NO_COEFF},
    '{ROW_CFG, tpss_pkg::REG_POLY_LENGTH, 16'h0003, 31'h0, 1'b0, NO_COEFF},
    '{ROW_WORD, REG_UNUSED, 16'h0000, 31'h0000_0001, 1'b1,
      '{18'h3FFFF, 16'd65534, 10'd0, 1'b0}},
    '{ROW_WORD, REG_UNUSED, 16'h0000, 31'h0000_0000, 1'b1, '{18'd1, 16'd1, 10'd1, 1'b0}},
    '{ROW_WORD, REG_UNUSED, 16'h0000, 31'h0000_0000, 1'b1, '{18'd0, 16'd0, 10'd2, 1'b1}},
    // A write to the undecoded index must leave everything as it was.
    '{ROW_CFG, REG_UNUSED, 16'hFFFF, 31'h0, 1'b0, NO_COEFF},
    '{ROW_WORD, REG_UNUSED, 16'h0000, 31'h0000_0002, 1'b1, '{18'd0, 16'd0, 10'd0, 1'b0}},
    // Length above the store saturates; raised mid-polynomial.
    '{ROW_CFG, tpss_pkg::REG_POLY_LENGTH, 16'hFFFF, 31'h0, 1'b0, NO_COEFF},
    '{ROW_WORD, REG_UNUSED, 16'h0000, 31'h0000_0005, 1'b0, NO_COEFF},
    '{ROW_WORD, REG_UNUSED, 16'h0000, 31'h7FFF_FFFF, 1'b0, NO_COEFF},
    // Lowered below the position: restart at coefficient zero with a large offset.
    '{ROW_CFG, tpss_pkg::REG_POLY_LENGTH, 16'h0002, 31'h0, 1'b0, NO_COEFF},
    '{ROW_CFG, tpss_pkg::REG_FIRST_OFFSET, 16'h8000, 31'h0, 1'b0, NO_COEFF},
    '{ROW_CFG, tpss_pkg::REG_MODULUS, 16'h0003, 31'h0, 1'b0, NO_COEFF},
    '{ROW_WORD, REG_UNUSED, 16'h0000, 31'h0000_0000, 1'b1,
      '{18'd32768, 16'd2, 10'd0, 1'b0}},
    '{ROW_WORD, REG_UNUSED, 16'h0000, 31'h0000_0001, 1'b1, '{18'd0, 16'd0, 10'd1, 1'b1}},
    // A full polynomial of seven.
    '{ROW_CFG, tpss_pkg::REG_POLY_LENGTH, 16'h0007, 31'h0, 1'b0, NO_COEFF},
    '{ROW_WORD, REG_UNUSED, 16'h0000, 31'h0000_0003, 1'b0, NO_COEFF},
    '{ROW_WORD, REG_UNUSED, 16'h0000, 31'h4000_0000, 1'b0, NO_COEFF},
    '{ROW_WORD, REG_UNUSED, 16'h0000, 31'h0000_0006, 1'b0, NO_COEFF},
    '{ROW_WORD, REG_UNUSED, 16'h0000, 31'h0000_0001, 1'b0, NO_COEFF},
    '{ROW_WORD, REG_UNUSED, 16'h0000, 31'h0000_0000, 1'b0, NO_COEFF},
    '{ROW_WORD, REG_UNUSED, 16'h0000, 31'h0000_0000, 1'b0, NO_COEFF},
    '{ROW_WORD, REG_UNUSED, 16'h0000, 31'h0000_0000, 1'b0, NO_COEFF}
  };

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [tpss_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [tpss_pkg::CFG_DATA_W-1:0] cfg_data_i;

  tpss_in_if  in_if ();
  tpss_out_if out_if ();

  ternary_poly_shuffle_sampler_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // Shadow copy of the registers and the shuffle state.
  logic [tpss_pkg::PL_W-1:0] reg_len;
  logic [tpss_pkg::CR_W-1:0] reg_q;
  logic [tpss_pkg::CR_W-1:0] reg_offset;
  int unsigned               shuffle_pos;
  logic [1:0]                moved_code [STORE_DEPTH];
  bit [STORE_DEPTH-1:0]      moved_set;

  coeff_t pending_coeffs [$];
  int     mismatches;
  bit     calm;
  bit     backpressure_req;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #4ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    if (mismatches < PRINT_LIMIT) begin
      $display("%0t ns: %s", $time, msg);
    end
    mismatches++;
  endtask

  // Record the coefficient that an accepted word is to produce.
  task automatic queue_coeff(input coeff_t c);
    pending_coeffs.insert(pending_coeffs.size(), c);
  endtask

  // Value now held at position x of the shuffled polynomial.
  function automatic logic [1:0] code_at(input int unsigned x, input int unsigned len);
    int unsigned third;
    third = len / 3;
    if (moved_set[x]) return moved_code[x];
    if (x < third) return tpss_pkg::CODE_PLUS;
    if (x < 2 * third) return tpss_pkg::CODE_MINUS;
    return tpss_pkg::CODE_ZERO;
  endfunction

  // One Fisher-Yates step: emit the value at j as coefficient i, move i to j.
  task automatic shuffle_step(input logic [tpss_pkg::RW_W-1:0] word, output coeff_t c);
    int unsigned len;
    int unsigned i;
    int unsigned j;
    logic [1:0]  cj;
    int          v;
    longint      q;
    longint      r;
    len = (reg_len == 0) ? 1 : ((reg_len > STORE_DEPTH) ? STORE_DEPTH : reg_len);
    if (shuffle_pos >= len) begin
      moved_set   = '0;
      shuffle_pos = 0;
    end
    i  = shuffle_pos;
    j  = (32'(word) % (len - i)) + i;
    cj = code_at(j, len);
    moved_code[j] = code_at(i, len);
    moved_set[j]  = 1'b1;
    v = (cj == tpss_pkg::CODE_PLUS) ? 1 : ((cj == tpss_pkg::CODE_MINUS) ? -1 : 0);
    if (i == 0) v += int'(reg_offset);
    // Floor modulo; a zero modulus yields zero.
    q = longint'(reg_q);
    if (q == 0) r = 0;
    else if (v >= 0) r = longint'(v) % q;
    else r = (q - ((-longint'(v)) % q)) % q;
    c.cs   = v[tpss_pkg::CS_W-1:0];
    c.cr   = r[tpss_pkg::CR_W-1:0];
    c.idx  = i[tpss_pkg::CI_W-1:0];
    c.last = (i == len - 1);
    if (c.last) begin
      moved_set   = '0;
      shuffle_pos = 0;
    end else begin
      shuffle_pos = i + 1;
    end
  endtask

  // Offer one word, possibly after an idle burst, and predict its coefficient.
  task automatic offer_word(input logic [tpss_pkg::RW_W-1:0] word, output coeff_t c);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.random_word <= word;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    shuffle_step(word, c);
  endtask

  // Stop offering and wait until every coefficient has come out.
  task automatic drain_outstanding();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_coeffs.size() != 0);
  endtask

  task automatic write_register(input logic [tpss_pkg::CFG_IDX_W-1:0] idx,
                                input logic [tpss_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      tpss_pkg::REG_POLY_LENGTH:  reg_len    = data[tpss_pkg::PL_W-1:0];
      tpss_pkg::REG_MODULUS:      reg_q      = data;
      tpss_pkg::REG_FIRST_OFFSET: reg_offset = data;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic check_coeff(input coeff_t got);
    coeff_t want;
    if (pending_coeffs.size() == 0) begin
      flag_mismatch($sformatf("unexpected coefficient index %0d", got.idx));
    end else begin
      want = pending_coeffs.pop_front();
      if (got.cs !== want.cs)
        flag_mismatch($sformatf("coeff_signed %0d, expected %0d (index %0d)",
                                got.cs, want.cs, want.idx));
      if (got.cr !== want.cr)
        flag_mismatch($sformatf("coeff_reduced %0d, expected %0d (index %0d)",
                                got.cr, want.cr, want.idx));
      if (got.idx !== want.idx)
        flag_mismatch($sformatf("coeff_index %0d, expected %0d", got.idx, want.idx));
      if (got.last !== want.last)
        flag_mismatch($sformatf("last %0b, expected %0b (index %0d)",
                                got.last, want.last, want.idx));
    end
  endtask

  // Output side: check each beat, stall in random bursts, hold off once on request.
  initial begin
    int stall_left;
    int hold_left;
    stall_left   = 0;
    hold_left    = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        check_coeff('{out_if.coeff_signed, out_if.coeff_reduced,
                      out_if.coeff_index, out_if.last});
      end
      if (backpressure_req) begin
        backpressure_req = 1'b0;
        hold_left        = BACKPRESSURE_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (!calm && rst_ni && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 7);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Reset, directed table, random phases, then the final drain.
  initial begin
    coeff_t      c;
    int          words_sent;
    int          phase;
    int          burst;
    int          k;
    logic [15:0] data;
    logic [tpss_pkg::RW_W-1:0] word;
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = tpss_pkg::REG_POLY_LENGTH;
    cfg_data_i        = '0;
    in_if.valid       = 1'b0;
    in_if.random_word = '0;
    mismatches        = 0;
    calm              = 1'b0;
    backpressure_req  = 1'b0;
    reg_len           = tpss_pkg::POLY_LENGTH_RST;
    reg_q             = tpss_pkg::MODULUS_RST;
    reg_offset        = tpss_pkg::FIRST_OFFSET_RST;
    shuffle_pos       = 0;
    moved_set         = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table.
    for (k = 0; k < PLAN_ROWS; k++) begin
      if (PLAN[k].kind == ROW_CFG) begin
        drain_outstanding();
        write_register(PLAN[k].reg_idx, PLAN[k].data);
      end else begin
        offer_word(PLAN[k].word, c);
        queue_coeff(PLAN[k].typed ? PLAN[k].want : c);
      end
    end

    // Random phases: new settings while idle, then a run of words.
    words_sent = 0;
    phase      = 0;
    while (words_sent < RANDOM_WORDS) begin
      drain_outstanding();
      case ($urandom_range(0, 9))
        0:       data = 16'($urandom_range(0, 16'hFFFF));
        1:       data = 16'd1024;
        2:       data = 16'd0;
        3:       data = 16'($urandom_range(1, 3));
        default: data = 16'($urandom_range(1, 40));
      endcase
      if (phase == 0 || $urandom_range(0, 2) != 0)
        write_register(tpss_pkg::REG_POLY_LENGTH, data);
      case ($urandom_range(0, 7))
        0:       data = 16'd0;
        1:       data = 16'd1;
        2:       data = 16'hFFFF;
        3:       data = 16'd2;
        default: data = 16'($urandom_range(2, 16'hFFFF));
      endcase
      if (phase == 0 || $urandom_range(0, 1) != 0)
        write_register(tpss_pkg::REG_MODULUS, data);
      case ($urandom_range(0, 3))
        0:       data = 16'd0;
        1:       data = 16'hFFFF;
        default: data = 16'($urandom_range(0, 16'hFFFF));
      endcase
      if (phase == 0 || $urandom_range(0, 1) != 0)
        write_register(tpss_pkg::REG_FIRST_OFFSET, data);
      if ($urandom_range(0, 7) == 0)
        write_register(REG_UNUSED, 16'($urandom_range(0, 16'hFFFF)));

      burst = $urandom_range(1, 60);
      // One phase backs the block up behind a long receiver hold.
      if (phase == 3) begin
        burst            = 40;
        backpressure_req = 1'b1;
      end
      for (k = 0; k < burst && words_sent < RANDOM_WORDS; k++) begin
        case ($urandom_range(0, 15))
          0:       word = '0;
          1:       word = '1;
          2:       word = tpss_pkg::RW_W'($urandom_range(0, 63));
          default: word = tpss_pkg::RW_W'($urandom());
        endcase
        offer_word(word, c);
        queue_coeff(c);
        words_sent++;
        if (words_sent >= RANDOM_WORDS * 85 / 100) calm = 1'b1;
      end
      phase++;
    end

    // Let the last coefficients out, then judge.
    in_if.valid <= 1'b0;
    for (k = 0; k < DRAIN_LIMIT && pending_coeffs.size() != 0; k++) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_coeffs.size() != 0)
      flag_mismatch($sformatf("%0d coefficients never arrived", pending_coeffs.size()));
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
